[rtl/mbhm_pkg.sv]
// Shared types, constants and arithmetic helpers for the masked bilinear height merge.
// Depends on nothing; every other file of the block imports it.
package mbhm_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] REG_ENABLE_MASK = 3'd0;
   localparam logic [2:0] REG_COL_ORIGIN  = 3'd1;
   localparam logic [2:0] REG_COL_STEP    = 3'd2;
   localparam logic [2:0] REG_ROW_ORIGIN  = 3'd3;
   localparam logic [2:0] REG_ROW_STEP    = 3'd4;

   localparam logic [16:0] RECIP_FIVE = 17'd52429;
   localparam int RECIP_SHIFT = 18;
   localparam logic signed [15:0] HEIGHT_OFFSET = 16'sd1000;
   localparam logic signed [19:0] RASTER_OFFSET = 20'sd16000;

   typedef enum logic [1:0] {CMD_LOAD, CMD_RASTER, CMD_MASK} cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  addr;
      logic [15:0]  data;
      logic [7:0]   r0;
      logic [7:0]   r1;
      logic [7:0]   c0;
      logic [7:0]   c1;
      logic [15:0]  fy;
      logic [15:0]  fx;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic        enable;
      logic [23:0] col_origin;
      logic [23:0] col_step;
      logic [23:0] row_origin;
      logic [23:0] row_step;
   } cfg_type;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_MASK, B_OUT} back_state_type;

   function automatic logic [15:0] encode_raster(input logic signed [18:0] r);
      logic signed [19:0] t;
      logic [21:0] p;
      logic [17:0] c;
      t = $signed({r[18], r}) + RASTER_OFFSET;
      p = {3'b0, t[18:0]} + {1'b0, t[18:0], 2'b0};
      c = p[21:4];
      if (t[19]) begin
         encode_raster = 16'd0;
      end else if (c > 18'd65535) begin
         encode_raster = 16'hFFFF;
      end else begin
         encode_raster = c[15:0];
      end
   endfunction

   function automatic logic signed [15:0] decode_code(input logic [15:0] code);
      logic [32:0] p;
      logic [14:0] q;
      p = 33'(code) * 33'(RECIP_FIVE);
      q = p[RECIP_SHIFT+14:RECIP_SHIFT];
      decode_code = $signed({1'b0, q}) - HEIGHT_OFFSET;
   endfunction

   function automatic logic [15:0] encode_mask(input logic signed [51:0] v);
      logic [53:0] p;
      logic [21:0] c;
      p = {3'b0, v[50:0]} + {1'b0, v[50:0], 2'b0};
      c = p[53:32];
      if (v[51]) begin
         encode_mask = 16'd0;
      end else if (c > 22'd65535) begin
         encode_mask = 16'hFFFF;
      end else begin
         encode_mask = c[15:0];
      end
   endfunction

endpackage

[rtl/mbhm_front.sv]
// Front end: accepts beats, tracks load address and tile position, classifies each
// beat and works out mask neighbours and fractions. Depends on mbhm_pkg.
module mbhm_front #(
   parameter int TILE_EDGE = 65,
   parameter int MASK_EDGE = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [15:0]              req_mask_word,
   input  logic signed [18:0]       req_raster_height,
   input  mbhm_pkg::cfg_type        cfg,
   input  mbhm_pkg::q_stat_type     q_stat,
   output logic                     push,
   output mbhm_pkg::cmd_type        push_cmd
);
   import mbhm_pkg::*;

   localparam int TILE_W = $clog2(TILE_EDGE);
   localparam int MASK_WORDS = MASK_EDGE * MASK_EDGE;
   localparam int MASK_AW = $clog2(MASK_WORDS);
   localparam int PROD_W = 24 + TILE_W;
   localparam logic [31:0] POS_LIMIT = 32'(MASK_EDGE - 1) << 16;
   localparam logic [TILE_W-1:0] TILE_END = TILE_W'(TILE_EDGE - 1);

   front_state_type state_ff, state_in;
   logic [MASK_AW-1:0] load_addr_ff;
   logic [TILE_W-1:0] row_ff, col_ff, irow_ff, icol_ff;
   logic mode_ff, last_ff;
   logic [15:0] word_ff;
   logic signed [18:0] height_ff;
   logic [MASK_AW-1:0] iaddr_ff;
   logic [PROD_W-1:0] prod_r_ff, prod_c_ff;
   logic accept;
   logic [31:0] pos_r, pos_c;

   assign accept = req_valid && (state_ff == F_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = req_mode ? F_MUL : F_PUSH;
         end
         F_MUL: state_in = F_PUSH;
         F_PUSH: begin
            if (!q_stat.full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != F_IDLE);
      push = (state_ff == F_PUSH) && !q_stat.full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         load_addr_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && !req_mode) begin
            load_addr_ff <= (load_addr_ff == MASK_AW'(MASK_WORDS - 1)) ? '0
                            : load_addr_ff + 1'b1;
         end
         if (accept && req_mode) begin
            if (col_ff >= TILE_END) begin
               col_ff <= '0;
               row_ff <= (row_ff >= TILE_END) ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         word_ff <= req_mask_word;
         height_ff <= req_raster_height;
         iaddr_ff <= load_addr_ff;
         irow_ff <= row_ff;
         icol_ff <= col_ff;
         last_ff <= (row_ff == TILE_END) && (col_ff == TILE_END);
      end
      if (state_ff == F_MUL) begin
         prod_r_ff <= PROD_W'(cfg.row_step) * PROD_W'(irow_ff);
         prod_c_ff <= PROD_W'(cfg.col_step) * PROD_W'(icol_ff);
      end
   end

   always_comb begin
      pos_r = 32'(cfg.row_origin) + 32'(prod_r_ff);
      pos_c = 32'(cfg.col_origin) + 32'(prod_c_ff);
      if (pos_r > POS_LIMIT) pos_r = POS_LIMIT;
      if (pos_c > POS_LIMIT) pos_c = POS_LIMIT;
      push_cmd.addr = 16'(iaddr_ff);
      push_cmd.last = last_ff;
      push_cmd.fy = pos_r[15:0];
      push_cmd.fx = pos_c[15:0];
      push_cmd.r0 = pos_r[23:16];
      push_cmd.c0 = pos_c[23:16];
      push_cmd.r1 = (pos_r[15:0] != 16'd0) ? pos_r[23:16] + 8'd1 : pos_r[23:16];
      push_cmd.c1 = (pos_c[15:0] != 16'd0) ? pos_c[23:16] + 8'd1 : pos_c[23:16];
      if (!mode_ff) begin
         push_cmd.kind = CMD_LOAD;
         push_cmd.data = word_ff;
      end else if (cfg.enable && (height_ff <= 19'sd0)) begin
         push_cmd.kind = CMD_MASK;
         push_cmd.data = encode_raster(height_ff);
      end else begin
         push_cmd.kind = CMD_RASTER;
         push_cmd.data = encode_raster(height_ff);
      end
   end

endmodule

[rtl/mbhm_queue.sv]
// Short command queue between the front and back ends of the height merge.
// Depends on mbhm_pkg.
module mbhm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mbhm_pkg::cmd_type     push_cmd,
   input  logic                  pop,
   output mbhm_pkg::cmd_type     head,
   output mbhm_pkg::q_stat_type  stat
);
   import mbhm_pkg::*;

   cmd_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_comb begin
      head = entry_ff[rd_ptr_ff];
      stat.full = (count_ff == QCNT_W'(QUEUE_DEPTH));
      stat.empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

[rtl/mbhm_back.sv]
// Back end: owns the mask memory, reads four neighbours per masked pixel, interpolates
// and drives the result register. Depends on mbhm_pkg.
module mbhm_back #(
   parameter int MASK_EDGE = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mbhm_pkg::q_stat_type  q_stat,
   input  mbhm_pkg::cmd_type     head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_height_code,
   output logic                  rsp_tile_last
);
   import mbhm_pkg::*;

   localparam int MASK_WORDS = MASK_EDGE * MASK_EDGE;
   localparam int MASK_AW = $clog2(MASK_WORDS);
   localparam logic [3:0] LAST_STEP = 4'd9;
   localparam logic signed [51:0] V_BIAS = 52'(HEIGHT_OFFSET) << 32;

   back_state_type state_ff, state_in;
   logic [3:0] step_ff;
   cmd_type cmd_ff;
   logic [15:0] mask_mem_ff [MASK_WORDS];
   logic [15:0] rdata_ff;
   logic signed [15:0] h_ff [4];
   logic signed [33:0] p0_ff, p1_ff, w_ff, e_ff;
   logic signed [51:0] p2_ff, v_ff;
   logic [15:0] code_ff;
   logic rsp_valid_ff, rsp_last_ff;
   logic [15:0] rsp_code_ff;
   logic out_free, mem_we;
   logic [7:0] rd_row, rd_col;
   logic [MASK_AW-1:0] raddr;
   logic signed [16:0] fy_s, fx_s, d0, d1;
   logic signed [34:0] dwe;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               unique case (head.kind)
                  CMD_MASK: state_in = B_MASK;
                  CMD_RASTER: state_in = B_OUT;
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_MASK: begin
            if (step_ff == LAST_STEP) state_in = B_OUT;
         end
         B_OUT: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop = (state_ff == B_IDLE) && !q_stat.empty;
      mem_we = pop && (head.kind == CMD_LOAD);
      rd_row = step_ff[0] ? cmd_ff.r1 : cmd_ff.r0;
      rd_col = step_ff[1] ? cmd_ff.c1 : cmd_ff.c0;
      raddr = MASK_AW'(17'(rd_row) * 17'(MASK_EDGE) + 17'(rd_col));
      fy_s = $signed({1'b0, cmd_ff.fy});
      fx_s = $signed({1'b0, cmd_ff.fx});
      d0 = $signed({h_ff[1][15], h_ff[1]}) - $signed({h_ff[0][15], h_ff[0]});
      d1 = $signed({h_ff[3][15], h_ff[3]}) - $signed({h_ff[2][15], h_ff[2]});
      dwe = $signed({e_ff[33], e_ff}) - $signed({w_ff[33], w_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= (state_ff == B_MASK) ? step_ff + 4'd1 : 4'd0;
         if (state_ff == B_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mask_mem_ff[head.addr[MASK_AW-1:0]] <= head.data;
      rdata_ff <= mask_mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head;
         code_ff <= head.data;
      end
      if (state_ff == B_MASK) begin
         if (step_ff != 4'd0 && step_ff <= 4'd4) begin
            h_ff[2'(step_ff - 4'd1)] <= decode_code(rdata_ff);
         end
         if (step_ff == 4'd5) begin
            p0_ff <= d0 * fy_s;
            p1_ff <= d1 * fy_s;
         end
         if (step_ff == 4'd6) begin
            w_ff <= $signed({{2{h_ff[0][15]}}, h_ff[0], 16'b0}) + p0_ff;
            e_ff <= $signed({{2{h_ff[2][15]}}, h_ff[2], 16'b0}) + p1_ff;
         end
         if (step_ff == 4'd7) p2_ff <= dwe * fx_s;
         if (step_ff == 4'd8) begin
            v_ff <= $signed({{2{w_ff[33]}}, w_ff, 16'b0}) + p2_ff + V_BIAS;
         end
         if (step_ff == LAST_STEP) code_ff <= encode_mask(v_ff);
      end
      if (state_ff == B_OUT && out_free) begin
         rsp_code_ff <= code_ff;
         rsp_last_ff <= cmd_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_height_code = rsp_code_ff;
   assign rsp_tile_last = rsp_last_ff;

endmodule

[rtl/masked_bilinear_height_merge.sv]
// Top level of the masked bilinear height merge: register port, front end, queue, back end.
// Depends on mbhm_pkg, mbhm_front, mbhm_queue and mbhm_back.
//
//   channel   direction  handshake            beat contents
//   req       in         req_valid/req_stall  mode, mask_word, raster_height
//   rsp       out        rsp_valid/rsp_stall  height_code, tile_last
//   csr       in/out     APB-style, 5-bit     enable_mask, origins and steps
//
// The front end holds one beat at a time and stalls the next until it is pushed; a pixel
// beat also passes a multiply state. The back end writes a load into the mask memory as it
// pops it, and for a masked pixel reads four neighbours and runs the interpolation chain.
// Reset clears positions, load address, registers and the queue; the mask memory is not
// cleared. A stalled result register backs up into the queue and then the front end.
module masked_bilinear_height_merge #(
   parameter int TILE_EDGE = 65,
   parameter int MASK_EDGE = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [15:0]        req_mask_word,
   input  logic signed [18:0] req_raster_height,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_height_code,
   output logic               rsp_tile_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import mbhm_pkg::*;

   cfg_type cfg_ff;
   q_stat_type q_stat;
   cmd_type push_cmd, head;
   logic push, pop;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            REG_ENABLE_MASK: cfg_ff.enable <= csr_pwdata[0];
            REG_COL_ORIGIN: cfg_ff.col_origin <= csr_pwdata[23:0];
            REG_COL_STEP: cfg_ff.col_step <= csr_pwdata[23:0];
            REG_ROW_ORIGIN: cfg_ff.row_origin <= csr_pwdata[23:0];
            REG_ROW_STEP: cfg_ff.row_step <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ENABLE_MASK: csr_prdata = {31'b0, cfg_ff.enable};
         REG_COL_ORIGIN: csr_prdata = {8'b0, cfg_ff.col_origin};
         REG_COL_STEP: csr_prdata = {8'b0, cfg_ff.col_step};
         REG_ROW_ORIGIN: csr_prdata = {8'b0, cfg_ff.row_origin};
         REG_ROW_STEP: csr_prdata = {8'b0, cfg_ff.row_step};
         default: csr_prdata = 32'd0;
      endcase
   end

   mbhm_front #(.TILE_EDGE(TILE_EDGE), .MASK_EDGE(MASK_EDGE)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_mask_word(req_mask_word), .req_raster_height(req_raster_height),
      .cfg(cfg_ff), .q_stat(q_stat), .push(push), .push_cmd(push_cmd)
   );

   mbhm_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd),
      .pop(pop), .head(head), .stat(q_stat)
   );

   mbhm_back #(.MASK_EDGE(MASK_EDGE)) u_back (
      .clock(clock), .reset(reset), .q_stat(q_stat), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_height_code(rsp_height_code), .rsp_tile_last(rsp_tile_last)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full) else $error("Queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("Queue read while empty.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> q_stat.empty) else $error("Queue not empty after reset.");

endmodule

[dv/masked_bilinear_height_merge_test.sv]
// Self-checking testbench for masked_bilinear_height_merge: loads the mask store, writes the
// registers between phases and checks every result against an in-bench height model.
// Depends on mbhm_pkg and the RTL of the block.
`timescale 1ns / 100ps

module masked_bilinear_height_merge_test;
   import mbhm_pkg::*;

   localparam int TILE_EDGE = 65;
   localparam int MASK_EDGE = 256;
   localparam int MASK_WORDS = MASK_EDGE * MASK_EDGE;
   localparam int LOAD_ROWS = 4;
   localparam int LOAD_WORDS = LOAD_ROWS * MASK_EDGE;
   localparam int ROW_SPAN = (LOAD_ROWS - 2) << 16;
   localparam int SETTLE = 40;
   localparam int STALL_LIMIT = 3000;
   localparam logic [2:0] REG_UNUSED = 3'd5;
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   typedef struct {
      logic [15:0] code;
      logic        last;
   } height_beat_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_mode;
   logic [15:0]        req_mask_word;
   logic signed [18:0] req_raster_height;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [15:0]        rsp_height_code;
   logic               rsp_tile_last;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [4:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   logic [15:0]     mask_image [MASK_WORDS];
   int unsigned     load_ptr;
   int unsigned     tile_row;
   int unsigned     tile_col;
   logic            cfg_enable;
   logic [23:0]     cfg_col_origin;
   logic [23:0]     cfg_col_step;
   logic [23:0]     cfg_row_origin;
   logic [23:0]     cfg_row_step;
   height_beat_type pending_heights[$];
   int              mismatches;
   int              idle_cycles;
   logic            send_calm;
   logic            drain_calm;

   masked_bilinear_height_merge #(
      .TILE_EDGE(TILE_EDGE),
      .MASK_EDGE(MASK_EDGE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_mask_word(req_mask_word),
      .req_raster_height(req_raster_height),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_height_code(rsp_height_code),
      .rsp_tile_last(rsp_tile_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint mask_metres(int unsigned row, int unsigned col);
      return longint'(mask_image[row * MASK_EDGE + col] / 16'd5) - 1000;
   endfunction

   function automatic void split_position(input longint pos, output int unsigned lo,
                                          output int unsigned hi, output longint frac);
      longint limit;
      limit = longint'(MASK_EDGE - 1) << 16;
      if (pos > limit) begin
         pos = limit;
      end
      lo = int'(pos >> 16);
      frac = pos & 64'hFFFF;
      hi = (frac != 0) ? lo + 1 : lo;
   endfunction

   function automatic logic [15:0] merged_height(logic signed [18:0] raster);
      longint      t;
      longint      fy;
      longint      fx;
      longint      w;
      longint      e;
      longint      v;
      int unsigned r0;
      int unsigned r1;
      int unsigned c0;
      int unsigned c1;
      if (!cfg_enable || raster > 0) begin
         t = longint'(raster) + 16000;
         if (t < 0) begin
            return 16'd0;
         end
         t = (t * 5) >>> 4;
         return (t > 65535) ? 16'hFFFF : t[15:0];
      end
      split_position(longint'(cfg_row_origin) + longint'(cfg_row_step) * tile_row, r0, r1, fy);
      split_position(longint'(cfg_col_origin) + longint'(cfg_col_step) * tile_col, c0, c1, fx);
      w = mask_metres(r0, c0) * (65536 - fy) + mask_metres(r1, c0) * fy;
      e = mask_metres(r0, c1) * (65536 - fy) + mask_metres(r1, c1) * fy;
      v = w * (65536 - fx) + e * fx + (longint'(1000) << 32);
      if (v < 0) begin
         return 16'd0;
      end
      v = (v * 5) >>> 32;
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic send_beat(logic mode, logic [15:0] word, logic signed [18:0] raster);
      int              gap;
      height_beat_type beat;
      gap = send_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_mask_word <= word;
      req_raster_height <= raster;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode == MODE_LOAD) begin
         mask_image[load_ptr] = word;
         load_ptr = (load_ptr + 1) % MASK_WORDS;
      end else begin
         beat.code = merged_height(raster);
         beat.last = (tile_row == TILE_EDGE - 1) && (tile_col == TILE_EDGE - 1);
         pending_heights.push_back(beat);
         if (tile_col == TILE_EDGE - 1) begin
            tile_col = 0;
            tile_row = (tile_row == TILE_EDGE - 1) ? 0 : tile_row + 1;
         end else begin
            tile_col++;
         end
      end
   endtask

   task automatic send_pixel(logic signed [18:0] raster);
      send_beat(MODE_PIXEL, 16'($urandom), raster);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [23:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {8'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (index)
         REG_ENABLE_MASK: cfg_enable = value[0];
         REG_COL_ORIGIN:  cfg_col_origin = value;
         REG_COL_STEP:    cfg_col_step = value;
         REG_ROW_ORIGIN:  cfg_row_origin = value;
         REG_ROW_STEP:    cfg_row_step = value;
         default: ;
      endcase
   endtask

   task automatic set_mapping(logic enable, logic [23:0] c_org, logic [23:0] c_step,
                              logic [23:0] r_org, logic [23:0] r_step);
      wait_idle();
      write_reg(REG_ENABLE_MASK, {23'd0, enable});
      write_reg(REG_COL_ORIGIN, c_org);
      write_reg(REG_COL_STEP, c_step);
      write_reg(REG_ROW_ORIGIN, r_org);
      write_reg(REG_ROW_STEP, r_step);
      write_reg(REG_UNUSED, 24'($urandom));
   endtask

   task automatic test_raster_encoding();
      logic signed [18:0] corners [10] = '{-19'sd262144, 19'sd262143, 19'sd0, 19'sd1,
         -19'sd1, -19'sd16000, -19'sd16001, -19'sd15999, 19'sd193712, 19'sd193713};
      foreach (corners[i]) send_pixel(corners[i]);
   endtask

   // Only the first mask rows are loaded; every mapping keeps its rows inside them.
   task automatic test_mask_load();
      logic [15:0] word;
      send_calm = 1'b1;
      for (int i = 0; i < LOAD_WORDS; i++) begin
         case (i)
            0:              word = 16'hFFFF;
            1:              word = 16'd4;
            2:              word = 16'd5;
            LOAD_WORDS - 1: word = 16'd0;
            default:        word = 16'($urandom);
         endcase
         send_beat(MODE_LOAD, word, 19'($urandom));
      end
      send_calm = 1'b0;
   endtask

   task automatic test_mask_corners();
      set_mapping(1'b1, 24'd0, 24'd0, 24'd0, 24'd0);
      send_pixel(19'sd0);
      send_pixel(-19'sd262144);
      send_pixel(19'sd1);
      set_mapping(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'h030000, 24'h000000);
      repeat (3) send_pixel(-19'sd5);
      set_mapping(1'b1, 24'h010000, 24'h010000, 24'h000000, 24'h008000);
      repeat (4) send_pixel(-19'($urandom_range(0, 262144)));
   endtask

   task automatic test_random_traffic();
      logic signed [18:0] raster;
      for (int phase = 0; phase < 5; phase++) begin
         set_mapping(phase != 4, 24'($urandom), 24'($urandom_range(0, 24'h40000)),
                     24'($urandom_range(0, 24'h10000)),
                     24'($urandom_range(0, ROW_SPAN / (TILE_EDGE - 1))));
         for (int i = 0; i < 90; i++) begin
            if (i % 30 == 0) begin
               send_calm = $urandom_range(0, 2) == 0;
            end
            if ($urandom_range(0, 9) == 0) begin
               send_beat(MODE_LOAD, 16'($urandom), 19'($urandom));
            end else begin
               raster = 19'($urandom);
               if ($urandom_range(0, 2) != 0) begin
                  raster = -19'($urandom_range(0, 262144));
               end
               send_pixel(raster);
            end
         end
         send_calm = 1'b0;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_LOAD;
      req_mask_word = '0;
      req_raster_height = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      load_ptr = 0;
      tile_row = 0;
      tile_col = 0;
      cfg_enable = 1'b0;
      cfg_col_origin = '0;
      cfg_col_step = '0;
      cfg_row_origin = '0;
      cfg_row_step = '0;
      mismatches = 0;
      send_calm = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_raster_encoding();
      test_mask_load();
      test_mask_corners();
      test_random_traffic();
      wait_idle();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      int hold;
      drain_calm = 1'b0;
      @(negedge reset);
      forever begin
         drain_calm = $urandom_range(0, 7) == 0 ? ~drain_calm : drain_calm;
         hold = drain_calm ? 0 : $urandom_range(0, 16);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      height_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_heights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected beat: code %0d last %0b", rsp_height_code, rsp_tile_last);
            end
         end else begin
            want = pending_heights.pop_front();
            if (want.code !== rsp_height_code || want.last !== rsp_tile_last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected code %0d last %0b, got code %0d last %0b",
                           want.code, want.last, rsp_height_code, rsp_tile_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[filelist.f]
rtl/mbhm_pkg.sv
rtl/mbhm_front.sv
rtl/mbhm_queue.sv
rtl/mbhm_back.sv
rtl/masked_bilinear_height_merge.sv
dv/masked_bilinear_height_merge_test.sv
